// ===== rtl/core/wsta_pkg.sv =====
package wsta_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned WeightW = 16;
  localparam int unsigned DurW    = 16;
  localparam int unsigned TaskW   = 32;
  localparam int unsigned SrvW    = 4;

  // item kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TASK = 1'b1;

  // one input beat
  typedef struct packed {
    logic               kind;
    logic [WeightW-1:0] weight;
    logic [DurW-1:0]    duration;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [SrvW-1:0] server;
    logic            no_server;
  } out_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic               clear;
    logic               load_en;
    logic [WeightW-1:0] weight;
    logic               free_en;
    logic [TimeW-1:0]   now;
    logic               assign_en;
    logic [TimeW-1:0]   finish;
  } ctl_t;

  // partial results handed from cell to cell along the row
  typedef struct packed {
    logic               any_free;
    logic               have_early;
    logic [TimeW-1:0]   early;
    logic               found;
    logic [WeightW-1:0] best_w;
  } carry_t;

endpackage

// ===== rtl/core/wsta_cell.sv =====
module wsta_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsta_pkg::ctl_t    ctl_i,
  input  logic [CW-1:0]     count_i,
  input  logic [IW-1:0]     load_idx_i,
  input  logic [IW-1:0]     assign_idx_i,
  input  logic              tok_i,
  input  wsta_pkg::carry_t  carry_i,
  input  logic [IW-1:0]     best_idx_i,
  output logic              tok_o,
  output wsta_pkg::carry_t  carry_o,
  output logic [IW-1:0]     best_idx_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [wsta_pkg::WeightW-1:0] weight_q;
  logic [wsta_pkg::TimeW-1:0]   finish_q;
  logic                         busy_q, busy_d;
  logic                         tok_q;
  wsta_pkg::carry_t             carry_q, carry_d;
  logic [IW-1:0]                best_idx_q, best_idx_d;
  logic                         loaded;
  logic                         load_me;
  logic                         assign_me;

  assign loaded    = count_i > CW'(IDX);
  assign load_me   = ctl_i.load_en && (load_idx_i == MyIdx);
  assign assign_me = ctl_i.assign_en && (assign_idx_i == MyIdx);

  // busy bit update
  always_comb begin
    busy_d = busy_q;
    if (ctl_i.clear || load_me) begin
      busy_d = 1'b0;
    end
    if (ctl_i.free_en && loaded && busy_q && (finish_q <= ctl_i.now)) begin
      busy_d = 1'b0;
    end
    if (assign_me) begin
      busy_d = 1'b1;
    end
  end

  // fold this server into the running scan results
  always_comb begin
    carry_d    = carry_i;
    best_idx_d = best_idx_i;
    if (loaded) begin
      if (!busy_q) begin
        carry_d.any_free = 1'b1;
      end else if (!carry_i.have_early || (finish_q < carry_i.early)) begin
        carry_d.early      = finish_q;
        carry_d.have_early = 1'b1;
      end
      if (!busy_q && (!carry_i.found || (weight_q < carry_i.best_w))) begin
        carry_d.found  = 1'b1;
        carry_d.best_w = weight_q;
        best_idx_d     = MyIdx;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tok_q  <= tok_i;
    end
  end

  // server entry and scan payload
  always_ff @(posedge clk_i) begin
    if (load_me) begin
      weight_q <= ctl_i.weight;
    end
    if (assign_me) begin
      finish_q <= ctl_i.finish;
    end
    if (tok_i) begin
      carry_q    <= carry_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign tok_o      = tok_q;
  assign carry_o    = carry_q;
  assign best_idx_o = best_idx_q;

endmodule

// ===== rtl/core/weighted_server_task_assigner_core.sv =====
// Weighted server task assigner. Load beats append a server weight at the next index (a load
// after tasks have run starts a new batch; loads past SERVERS are dropped); task beats get the
// free server of least (weight, index) and return one result beat. Each server lives in its own
// cell of a row; a scan token walks the row one cell per cycle. A task with no servers loaded
// goes straight from accept to assign; any other task takes two full token passes (earliest
// finish and free check, then least weight) plus accept, end-of-pass, free and assign steps.
// A stalled output holds the task in the assign step.
// A new beat is taken only while no task is in work; a finished result waits in the output
// register without blocking the input.
module weighted_server_task_assigner_core #(
  parameter int unsigned SERVERS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wsta_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wsta_pkg::out_t out_data_o
);

  localparam int unsigned IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int unsigned CW = $clog2(SERVERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_FREE,
    ST_SCAN2,
    ST_ASSIGN
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 count_q;
  logic [wsta_pkg::TimeW-1:0]    time_q;
  logic [wsta_pkg::TaskW-1:0]    tc_q;
  logic                          start_q;
  logic                          nosrv_q;
  logic                          out_valid_q;
  wsta_pkg::out_t                out_data_q;
  logic [wsta_pkg::DurW-1:0]     dur_q;
  logic [IW-1:0]                 best_q;

  wsta_pkg::ctl_t                ctl;
  logic [IW-1:0]                 load_idx;
  logic [IW-1:0]                 assign_idx;
  logic [CW-1:0]                 count_base;
  logic                          accept;
  logic                          out_free;
  logic [wsta_pkg::TimeW:0]      finish_sum;
  logic [wsta_pkg::TimeW-1:0]    arrival;

  logic                          tok   [SERVERS];
  wsta_pkg::carry_t              carry [SERVERS];
  logic [IW-1:0]                 bidx  [SERVERS];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign count_base  = (tc_q != '0) ? '0 : count_q;
  assign finish_sum  = {1'b0, time_q} + (wsta_pkg::TimeW + 1)'(dur_q);
  assign arrival     = wsta_pkg::TimeW'(tc_q);

  // broadcast controls for the cell row
  always_comb begin
    ctl        = '0;
    load_idx   = '0;
    assign_idx = best_q;
    ctl.weight = in_data_i.weight;
    ctl.now    = time_q;
    ctl.finish = finish_sum[wsta_pkg::TimeW] ? '1 : finish_sum[wsta_pkg::TimeW-1:0];
    if (accept && (in_data_i.kind == wsta_pkg::KIND_LOAD)) begin
      ctl.clear = (tc_q != '0);
      if (count_base < CW'(SERVERS)) begin
        ctl.load_en = 1'b1;
        load_idx    = count_base[IW-1:0];
      end
    end
    if (state_q == ST_FREE) begin
      ctl.free_en = 1'b1;
    end
    if ((state_q == ST_ASSIGN) && !nosrv_q && out_free) begin
      ctl.assign_en = 1'b1;
    end
  end

  // row of server cells
  for (genvar g = 0; g < SERVERS; g++) begin : g_cell
    logic             tok_in;
    wsta_pkg::carry_t carry_in;
    logic [IW-1:0]    bidx_in;

    if (g == 0) begin : g_head
      assign tok_in   = start_q;
      assign carry_in = '0;
      assign bidx_in  = '0;
    end else begin : g_link
      assign tok_in   = tok[g-1];
      assign carry_in = carry[g-1];
      assign bidx_in  = bidx[g-1];
    end

    wsta_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .load_idx_i   (load_idx),
      .assign_idx_i (assign_idx),
      .tok_i        (tok_in),
      .carry_i      (carry_in),
      .best_idx_i   (bidx_in),
      .tok_o        (tok[g]),
      .carry_o      (carry[g]),
      .best_idx_o   (bidx[g])
    );
  end

  // sequencer, batch state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      time_q      <= '0;
      tc_q        <= '0;
      start_q     <= 1'b0;
      nosrv_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // token launch for either pass
      start_q <= (accept && (in_data_i.kind == wsta_pkg::KIND_TASK) && (count_q != '0)) ||
                 (state_q == ST_FREE);
      if ((state_q == ST_ASSIGN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.kind == wsta_pkg::KIND_LOAD) begin
              if (tc_q != '0) begin
                tc_q   <= '0;
                time_q <= '0;
              end
              if (ctl.load_en) begin
                count_q <= count_base + CW'(1);
              end else begin
                count_q <= count_base;
              end
            end else if (count_q == '0) begin
              nosrv_q <= 1'b1;
              state_q <= ST_ASSIGN;
            end else begin
              if (time_q < arrival) begin
                time_q <= arrival;
              end
              nosrv_q <= 1'b0;
              state_q <= ST_SCAN1;
            end
          end
        end
        ST_SCAN1: begin
          if (tok[SERVERS-1]) begin
            if (!carry[SERVERS-1].any_free && carry[SERVERS-1].have_early &&
                (time_q < carry[SERVERS-1].early)) begin
              time_q <= carry[SERVERS-1].early;
            end
            state_q <= ST_FREE;
          end
        end
        ST_FREE: begin
          state_q <= ST_SCAN2;
        end
        ST_SCAN2: begin
          if (tok[SERVERS-1]) begin
            state_q <= ST_ASSIGN;
          end
        end
        ST_ASSIGN: begin
          if (out_free) begin
            out_data_q.no_server <= nosrv_q;
            out_data_q.server    <= nosrv_q ? '0 : wsta_pkg::SrvW'(best_q);
            if (!nosrv_q && (tc_q != '1)) begin
              tc_q <= tc_q + wsta_pkg::TaskW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // task payload held across the scans
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dur_q <= in_data_i.duration;
    end
    if ((state_q == ST_SCAN2) && tok[SERVERS-1]) begin
      best_q <= carry[SERVERS-1].found ? bidx[SERVERS-1] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/wsta_checker.sv =====
module wsta_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input wsta_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input wsta_pkg::out_t out_data_o
);

  logic [1:0] owed_q, owed_d;
  logic       task_beat;
  logic       out_beat;

  assign task_beat = in_valid_i && !in_stall_o && (in_data_i.kind == wsta_pkg::KIND_TASK);
  assign out_beat  = out_valid_o && !out_stall_i;

  // count of task beats still owed a result
  always_comb begin
    owed_d = owed_q;
    if (task_beat && !out_beat) begin
      owed_d = owed_q + 2'd1;
    end else if (!task_beat && out_beat) begin
      owed_d = owed_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_d;
    end
  end

  // result waits while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a missing-server result always names server zero
  a_nosrv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_server |-> out_data_o.server == '0)
    else $error("no_server result with nonzero server");

  // a result only answers an earlier task beat
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> owed_q != 2'd0)
    else $error("result beat without a pending task");

  // at most one task in work plus one result waiting
  a_owed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q != 2'd3)
    else $error("too many tasks owed a result");

endmodule

bind weighted_server_task_assigner_core wsta_checker u_wsta_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import wsta_pkg::*;

  localparam int unsigned NUM_SERVERS   = 16;
  localparam int unsigned ITEM_TARGET   = 1350;
  // one task beat spends two passes over the row plus overhead
  localparam int unsigned TASK_CYCLES   = 2 * NUM_SERVERS + 4;
  localparam int unsigned SETTLE_CYCLES = 2 * TASK_CYCLES;
  localparam int unsigned MAX_REPORTS   = 10;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  weighted_server_task_assigner_core #(
    .SERVERS (NUM_SERVERS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the server table
  logic [WeightW-1:0] srv_weight [NUM_SERVERS];
  logic               srv_busy   [NUM_SERVERS];
  logic [TimeW-1:0]   srv_finish [NUM_SERVERS];
  int unsigned        srv_count;
  logic [TimeW-1:0]   now_time;
  logic [TaskW-1:0]   tasks_done;

  out_t        pending_assignments[$];
  int unsigned mismatch_cnt;
  int unsigned items_sent;
  bit          idle_on;

  // append a server weight, opening a new batch if tasks have run
  function automatic void load_server(logic [WeightW-1:0] w);
    if (tasks_done != '0) begin
      for (int i = 0; i < NUM_SERVERS; i++) srv_busy[i] = 1'b0;
      srv_count  = 0;
      now_time   = '0;
      tasks_done = '0;
    end
    if (srv_count < NUM_SERVERS) begin
      srv_weight[srv_count] = w;
      srv_busy[srv_count]   = 1'b0;
      srv_count++;
    end
  endfunction

  // pick the free server of least (weight, index) for the next task
  function automatic out_t assign_task(logic [DurW-1:0] dur);
    out_t             res;
    bit               any_free;
    bit               have_early;
    logic [TimeW-1:0] early;
    int               best;
    logic [TimeW:0]   sum;

    res        = '0;
    any_free   = 1'b0;
    have_early = 1'b0;
    early      = '0;
    best       = -1;
    if (srv_count == 0) begin
      res.no_server = 1'b1;
      return res;
    end
    // task j arrives at time j
    if (now_time < TimeW'(tasks_done)) now_time = TimeW'(tasks_done);
    for (int i = 0; i < srv_count; i++) begin
      if (!srv_busy[i]) begin
        any_free = 1'b1;
      end else if (!have_early || srv_finish[i] < early) begin
        early      = srv_finish[i];
        have_early = 1'b1;
      end
    end
    // all busy: jump ahead to the earliest finish
    if (!any_free && have_early && now_time < early) now_time = early;
    for (int i = 0; i < srv_count; i++)
      if (srv_busy[i] && srv_finish[i] <= now_time) srv_busy[i] = 1'b0;
    for (int i = 0; i < srv_count; i++) begin
      if (srv_busy[i]) continue;
      if (best < 0 || srv_weight[i] < srv_weight[best]) best = i;
    end
    if (best < 0) best = 0;
    srv_busy[best] = 1'b1;
    sum = {1'b0, now_time} + (TimeW + 1)'(dur);
    srv_finish[best] = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    if (tasks_done != {TaskW{1'b1}}) tasks_done++;
    res.server = SrvW'(best);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // drive one beat and update the shadow table once it is taken
  task automatic send_beat(input in_t beat);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    if (beat.kind == KIND_LOAD) load_server(beat.weight);
    else pending_assignments.push_back(assign_task(beat.duration));
  endtask

  task automatic send_load(input logic [WeightW-1:0] w);
    in_t beat;
    beat.kind     = KIND_LOAD;
    beat.weight   = w;
    beat.duration = DurW'($urandom);
    send_beat(beat);
  endtask

  task automatic send_task(input logic [DurW-1:0] dur);
    in_t beat;
    beat.kind     = KIND_TASK;
    beat.weight   = WeightW'($urandom);
    beat.duration = dur;
    send_beat(beat);
  endtask

  // tasks before any server is loaded
  task automatic test_no_servers();
    send_task('0);
    send_task('1);
  endtask

  // one server: every task queues behind the previous one
  task automatic test_single_server();
    send_load('1);
    send_task('0);
    send_task('1);
    send_task(16'd3);
  endtask

  // full row with ties and extreme weights, one load past capacity
  task automatic test_full_batch();
    logic [WeightW-1:0] weights [17] = '{16'd7, 16'd0, 16'hFFFF, 16'd7, 16'd0, 16'd3,
                                         16'hFFFF, 16'd1, 16'd2, 16'd9, 16'd0, 16'd4,
                                         16'd8, 16'd5, 16'd6, 16'hFFFF, 16'd11};
    foreach (weights[i]) send_load(weights[i]);
    send_task('1);
    send_task('0);
    send_task(16'd1);
    send_task(16'd2);
  endtask

  // batches of loads followed by tasks, with some mixed noise
  task automatic test_random_batches();
    int unsigned n_load;
    int unsigned n_task;
    int unsigned wmode;
    int unsigned dmode;
    in_t         beat;
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: random kinds and contents
        repeat ($urandom_range(1, 20)) begin
          beat = in_t'($urandom);
          beat.kind = $urandom_range(0, 1) ? KIND_TASK : KIND_LOAD;
          beat.duration = DurW'($urandom_range(0, 40));
          send_beat(beat);
        end
        continue;
      end
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      wmode  = $urandom_range(0, 2);
      repeat (n_load) begin
        case (wmode)
          0:       send_load(WeightW'($urandom));
          1:       send_load(WeightW'($urandom_range(0, 3)));
          default: send_load($urandom_range(0, 1) ? '1 : WeightW'($urandom_range(0, 1)));
        endcase
      end
      n_task = $urandom_range(1, 40);
      dmode  = $urandom_range(0, 3);
      repeat (n_task) begin
        case (dmode)
          0:       send_task(DurW'($urandom_range(0, 2 * n_load)));
          1:       send_task(DurW'($urandom_range(0, 50)));
          2:       send_task(DurW'($urandom));
          default: send_task($urandom_range(0, 7) == 0 ? DurW'($urandom) :
                             DurW'($urandom_range(0, 4)));
        endcase
      end
    end
  endtask

  // receiver stall: random stretches, most short, a few long
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
                                                    $urandom_range(1, 4);
    end
  end

  // compare each result beat with the oldest expected assignment
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_assignments.size() == 0) begin
        report_error($sformatf("unexpected result server=%0d no_server=%0b",
                               out_data.server, out_data.no_server));
      end else begin
        exp_res = pending_assignments.pop_front();
        if (out_data.server !== exp_res.server ||
            out_data.no_server !== exp_res.no_server)
          report_error($sformatf("expected server=%0d no_server=%0b, got server=%0d no_server=%0b",
                                 exp_res.server, exp_res.no_server,
                                 out_data.server, out_data.no_server));
      end
    end
  end

  initial begin
    srv_count    = 0;
    now_time     = '0;
    tasks_done   = '0;
    mismatch_cnt = 0;
    items_sent   = 0;
    idle_on      = 1'b1;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      srv_weight[i] = '0;
      srv_busy[i]   = 1'b0;
      srv_finish[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_no_servers();
    test_single_server();
    test_full_batch();
    test_random_batches();
    in_valid <= 1'b0;

    // drain and let any stray beat show up
    while (pending_assignments.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_assignments.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wsta_pkg.sv
rtl/core/wsta_cell.sv
rtl/core/weighted_server_task_assigner_core.sv
rtl/core/wsta_checker.sv
verif/tb_top.sv
